// ===== hdl/tps_pkg.sv =====
package tps_pkg;

    // Width of every coordinate and id field on the ports.
    localparam int FIELD_W = 16;

    // Coordinates are taken as COORD_WIDTH-bit signed values, ids modulo 2^ID_WIDTH.
    localparam int COORD_WIDTH = 16;
    localparam int ID_WIDTH    = 16;

    // Coordinate differences, their products, and sums of products (edge values and their total).
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SUM_W  = PROD_W + 2;

    localparam int PIECE_W  = 2;
    localparam int PIECE_N  = 3;

    typedef enum logic [1:0] {
        STATUS_PIECE   = 2'd0,
        STATUS_OUTSIDE = 2'd1,
        STATUS_EMPTY   = 2'd2
    } status_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [SUM_W-1:0]       sum_t;
    typedef logic [ID_WIDTH-1:0]           id_t;

    function automatic coord_t to_coord(logic [FIELD_W-1:0] raw);
        return coord_t'(raw[COORD_WIDTH-1:0]);
    endfunction

    // a - b, one bit wider so that it never overflows.
    function automatic diff_t coord_diff(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
        diff_t da;
        diff_t db;
        da = diff_t'(to_coord(a));
        db = diff_t'(to_coord(b));
        return da - db;
    endfunction

    // True when p lies on the segment a-b and that segment is vertical or horizontal.
    function automatic logic on_axis_edge(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                          coord_t px, coord_t py);
        logic vert;
        logic horz;
        vert = (ax == bx) && (px == ax) &&
               (((py >= ay) && (py <= by)) || ((py >= by) && (py <= ay)));
        horz = (ay == by) && (py == ay) &&
               (((px >= ax) && (px <= bx)) || ((px >= bx) && (px <= ax)));
        return vert || horz;
    endfunction

    // Edge value n is on the same side as the doubled area den (den known nonzero).
    function automatic logic same_side(sum_t n, logic den_pos);
        if (den_pos) begin
            return !n[SUM_W-1];
        end
        return n[SUM_W-1] || (n == '0);
    endfunction

endpackage

// ===== hdl/triangle_point_split.sv =====
// Path: an item passes the input register (stage A), the product register (stage B),
// the job register (stage C) and the result register. An item yields 1 to 3 results,
// one per cycle on the result channel while m_ready does not stall it; a new item can be
// taken in every cycle while the three-stage pipeline has room.
// Reset: synchronous, active low; clears all valid flags and loads 0 into the id counter.
module triangle_point_split (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_v1_x,
    input  logic [15:0] s_v1_y,
    input  logic [15:0] s_v2_x,
    input  logic [15:0] s_v2_y,
    input  logic [15:0] s_v3_x,
    input  logic [15:0] s_v3_y,
    input  logic [15:0] s_pt_x,
    input  logic [15:0] s_pt_y,
    input  logic        s_on_boundary,
    input  logic [15:0] s_tri_id,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_initial_new_id,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [1:0]  m_piece,
    output logic [15:0] m_element_id,
    output logic        m_last
);

    // Stage A: input register.
    logic                          a_valid_reg;
    logic [tps_pkg::FIELD_W-1:0]   a_v1x_reg, a_v1y_reg, a_v2x_reg, a_v2y_reg;
    logic [tps_pkg::FIELD_W-1:0]   a_v3x_reg, a_v3y_reg, a_ptx_reg, a_pty_reg;
    logic                          a_bnd_reg;
    tps_pkg::id_t                  a_id_reg;

    // Stage B: edge-function products and the boundary rule.
    logic                          b_valid_reg;
    tps_pkg::prod_t                b_na1_reg, b_na2_reg, b_nb1_reg, b_nb2_reg;
    tps_pkg::prod_t                b_ng1_reg, b_ng2_reg;
    logic                          b_hit_reg;
    tps_pkg::id_t                  b_id_reg;

    // Stage C: job being issued as results.
    logic                          job_valid_reg;
    logic                          job_outside_reg;
    logic [tps_pkg::PIECE_N-1:0]   job_mask_reg;
    logic                          job_first_reg;
    tps_pkg::id_t                  job_id_reg;

    tps_pkg::id_t                  next_id_reg;

    logic                          m_valid_reg;
    tps_pkg::status_t              m_status_reg;
    logic [tps_pkg::PIECE_W-1:0]   m_piece_reg;
    logic [15:0]                   m_element_id_reg;
    logic                          m_last_reg;

    logic b_ready;
    logic c_ready;
    logic emit;
    logic job_done;

    // ---------------------------------------------------------------- stage A
    assign s_ready = !a_valid_reg || b_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_ready) begin
            a_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            a_v1x_reg <= s_v1_x;
            a_v1y_reg <= s_v1_y;
            a_v2x_reg <= s_v2_x;
            a_v2y_reg <= s_v2_y;
            a_v3x_reg <= s_v3_x;
            a_v3y_reg <= s_v3_y;
            a_ptx_reg <= s_pt_x;
            a_pty_reg <= s_pt_y;
            a_bnd_reg <= s_on_boundary;
            a_id_reg  <= tps_pkg::ID_WIDTH'(s_tri_id);
        end
    end

    // ---------------------------------------------------------------- stage B
    tps_pkg::coord_t x0, y0, x1, y1, x2, y2, px, py;
    logic            hit;

    always_comb begin
        x0 = tps_pkg::to_coord(a_v1x_reg);
        y0 = tps_pkg::to_coord(a_v1y_reg);
        x1 = tps_pkg::to_coord(a_v2x_reg);
        y1 = tps_pkg::to_coord(a_v2y_reg);
        x2 = tps_pkg::to_coord(a_v3x_reg);
        y2 = tps_pkg::to_coord(a_v3y_reg);
        px = tps_pkg::to_coord(a_ptx_reg);
        py = tps_pkg::to_coord(a_pty_reg);
        hit = a_bnd_reg &&
              (tps_pkg::on_axis_edge(x0, y0, x1, y1, px, py) ||
               tps_pkg::on_axis_edge(x1, y1, x2, y2, px, py) ||
               tps_pkg::on_axis_edge(x2, y2, x0, y0, px, py));
    end

    assign b_ready = !b_valid_reg || c_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
        if (a_valid_reg && b_ready) begin
            // na: edge v2-v3, nb: edge v3-v1, ng: edge v1-v2, all evaluated at the point.
            b_na1_reg <= tps_pkg::prod_t'(tps_pkg::coord_diff(a_v2y_reg, a_v3y_reg)) *
                         tps_pkg::prod_t'(tps_pkg::coord_diff(a_ptx_reg, a_v3x_reg));
            b_na2_reg <= tps_pkg::prod_t'(tps_pkg::coord_diff(a_v3x_reg, a_v2x_reg)) *
                         tps_pkg::prod_t'(tps_pkg::coord_diff(a_pty_reg, a_v3y_reg));
            b_nb1_reg <= tps_pkg::prod_t'(tps_pkg::coord_diff(a_v3y_reg, a_v1y_reg)) *
                         tps_pkg::prod_t'(tps_pkg::coord_diff(a_ptx_reg, a_v1x_reg));
            b_nb2_reg <= tps_pkg::prod_t'(tps_pkg::coord_diff(a_v1x_reg, a_v3x_reg)) *
                         tps_pkg::prod_t'(tps_pkg::coord_diff(a_pty_reg, a_v1y_reg));
            b_ng1_reg <= tps_pkg::prod_t'(tps_pkg::coord_diff(a_v1y_reg, a_v2y_reg)) *
                         tps_pkg::prod_t'(tps_pkg::coord_diff(a_ptx_reg, a_v2x_reg));
            b_ng2_reg <= tps_pkg::prod_t'(tps_pkg::coord_diff(a_v2x_reg, a_v1x_reg)) *
                         tps_pkg::prod_t'(tps_pkg::coord_diff(a_pty_reg, a_v2y_reg));
            b_hit_reg <= hit;
            b_id_reg  <= a_id_reg;
        end
    end

    // ---------------------------------------------------------------- stage C
    tps_pkg::sum_t na, nb, ng, den;
    logic          den_pos;
    logic          pt_in;

    always_comb begin
        na  = tps_pkg::sum_t'(b_na1_reg) + tps_pkg::sum_t'(b_na2_reg);
        nb  = tps_pkg::sum_t'(b_nb1_reg) + tps_pkg::sum_t'(b_nb2_reg);
        ng  = tps_pkg::sum_t'(b_ng1_reg) + tps_pkg::sum_t'(b_ng2_reg);
        // Together na, nb and ng add up to the doubled area of the triangle.
        den = na + nb + ng;
        den_pos = !den[tps_pkg::SUM_W-1] && (den != '0);
        pt_in = b_hit_reg ||
                ((den != '0) && tps_pkg::same_side(na, den_pos) &&
                 tps_pkg::same_side(nb, den_pos) && tps_pkg::same_side(ng, den_pos));
    end

    // Each piece's doubled area equals, up to sign, one edge function at the point.
    logic [tps_pkg::PIECE_N-1:0] keep;
    assign keep = {nb != '0, na != '0, ng != '0};

    // ---------------------------------------------------------------- issue
    tps_pkg::status_t             sel_status;
    logic [tps_pkg::PIECE_W-1:0]  sel_piece;
    logic [tps_pkg::PIECE_N-1:0]  sel_onehot;
    logic [tps_pkg::PIECE_N-1:0]  rest_mask;
    tps_pkg::id_t                 sel_id;
    logic                         sel_last;
    logic                         use_counter;

    always_comb begin
        sel_onehot = '0;
        sel_piece  = '0;
        priority if (job_mask_reg[0]) begin
            sel_onehot[0] = 1'b1;
            sel_piece     = tps_pkg::PIECE_W'(0);
        end else if (job_mask_reg[1]) begin
            sel_onehot[1] = 1'b1;
            sel_piece     = tps_pkg::PIECE_W'(1);
        end else if (job_mask_reg[2]) begin
            sel_onehot[2] = 1'b1;
            sel_piece     = tps_pkg::PIECE_W'(2);
        end else begin
            sel_onehot = '0;
        end
        rest_mask = job_mask_reg & ~sel_onehot;

        use_counter = 1'b0;
        if (job_outside_reg) begin
            sel_status = tps_pkg::STATUS_OUTSIDE;
            sel_piece  = '0;
            sel_id     = '0;
            sel_last   = 1'b1;
        end else if (job_mask_reg == '0) begin
            sel_status = tps_pkg::STATUS_EMPTY;
            sel_piece  = '0;
            sel_id     = '0;
            sel_last   = 1'b1;
        end else begin
            sel_status  = tps_pkg::STATUS_PIECE;
            sel_id      = job_first_reg ? job_id_reg : next_id_reg;
            use_counter = !job_first_reg;
            sel_last    = (rest_mask == '0);
        end
    end

    assign emit     = job_valid_reg && (!m_valid_reg || m_ready);
    assign job_done = emit && sel_last;
    assign c_ready  = !job_valid_reg || job_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
        end else if (c_ready) begin
            job_valid_reg <= b_valid_reg;
        end
        if (c_ready && b_valid_reg) begin
            job_outside_reg <= !pt_in;
            job_mask_reg    <= keep;
            job_first_reg   <= 1'b1;
            job_id_reg      <= b_id_reg;
        end else if (emit) begin
            job_mask_reg  <= rest_mask;
            job_first_reg <= 1'b0;
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_id_reg <= '0;
        end else if (cfg_valid) begin
            next_id_reg <= tps_pkg::ID_WIDTH'(cfg_initial_new_id);
        end else if (emit && use_counter) begin
            next_id_reg <= next_id_reg + tps_pkg::ID_WIDTH'(1);
        end
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= job_valid_reg;
        end
        if (emit) begin
            m_status_reg     <= sel_status;
            m_piece_reg      <= sel_piece;
            m_element_id_reg <= 16'(sel_id);
            m_last_reg       <= sel_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_piece      = m_piece_reg;
    assign m_element_id = m_element_id_reg;
    assign m_last       = m_last_reg;

endmodule

// ===== hdl/tps_checker.sv =====
module tps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [1:0]  m_piece,
    input logic [15:0] m_element_id,
    input logic        m_last
);

    // A result that is not a piece is always the only result of its item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != tps_pkg::STATUS_PIECE) |-> m_last)
        else $error("error result without last");

    // A result followed by more results of the same item is a piece, never the third one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> (m_status == tps_pkg::STATUS_PIECE) && (m_piece != 2'd2))
        else $error("non-final result is not an early piece");

    // Error results carry piece 0 and id 0.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != tps_pkg::STATUS_PIECE) |-> (m_piece == 2'd0) &&
        (m_element_id == 16'd0))
        else $error("error result carries a piece or id");

    // A stalled result holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_piece) &&
        $stable(m_element_id) && $stable(m_last))
        else $error("result changed while stalled");

endmodule

bind triangle_point_split tps_checker u_tps_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_piece      (m_piece),
    .m_element_id (m_element_id),
    .m_last       (m_last)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 120;
    localparam int MAX_GAP     = 12;

    typedef struct packed {
        tps_pkg::coord_t v1_x;
        tps_pkg::coord_t v1_y;
        tps_pkg::coord_t v2_x;
        tps_pkg::coord_t v2_y;
        tps_pkg::coord_t v3_x;
        tps_pkg::coord_t v3_y;
        tps_pkg::coord_t pt_x;
        tps_pkg::coord_t pt_y;
        logic            on_boundary;
        tps_pkg::id_t    tri_id;
    } tri_item_t;

    typedef struct packed {
        tps_pkg::status_t status;
        logic [1:0]       piece;
        tps_pkg::id_t     element_id;
        logic             last;
    } piece_result_t;

    // Predicts the pieces of each triangle and compares them with what the block returns.
    class split_scoreboard;
        piece_result_t expected_pieces[$];
        tps_pkg::id_t  next_piece_id;
        int            errors;
        int            triangles_seen;
        int            results_seen;
        int            status_seen[3];

        function new();
            next_piece_id = '0;
            errors = 0;
            triangles_seen = 0;
            results_seen = 0;
            status_seen = '{0, 0, 0};
        endfunction

        function void load_first_id(tps_pkg::id_t value);
            next_piece_id = value;
        endfunction

        function int pending();
            return expected_pieces.size();
        endfunction

        function void queue_result(piece_result_t r);
            expected_pieces.insert(expected_pieces.size(), r);
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) begin
                $display("%0t ns: mismatch: %s", $time, msg);
            end
        endfunction

        function bit on_straight_edge(longint ax, longint ay, longint bx, longint by,
                                      longint px, longint py);
            if (ax == bx && px == ax &&
                ((py >= ay && py <= by) || (py >= by && py <= ay))) begin
                return 1'b1;
            end
            if (ay == by && py == ay &&
                ((px >= ax && px <= bx) || (px >= bx && px <= ax))) begin
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function bit agrees(longint n, longint d);
            return (d > 0) ? (n >= 0) : (n <= 0);
        endfunction

        function void note_triangle(tri_item_t it);
            longint vx[3];
            longint vy[3];
            longint px;
            longint py;
            longint den;
            longint ea;
            longint eb;
            longint eg;
            longint area;
            int     from_v[3] = '{0, 1, 0};
            int     to_v[3] = '{1, 2, 2};
            int     a;
            int     b;
            int     kept;
            bit     accepted;
            piece_result_t r;

            triangles_seen++;
            vx[0] = it.v1_x;  vy[0] = it.v1_y;
            vx[1] = it.v2_x;  vy[1] = it.v2_y;
            vx[2] = it.v3_x;  vy[2] = it.v3_y;
            px = it.pt_x;
            py = it.pt_y;

            accepted = 1'b0;
            if (it.on_boundary) begin
                for (int i = 0; i < 3; i++) begin
                    if (on_straight_edge(vx[i], vy[i], vx[(i + 1) % 3], vy[(i + 1) % 3],
                                         px, py)) begin
                        accepted = 1'b1;
                    end
                end
            end
            if (!accepted) begin
                den = (vy[1] - vy[2]) * (vx[0] - vx[2]) + (vx[2] - vx[1]) * (vy[0] - vy[2]);
                ea  = (vy[1] - vy[2]) * (px - vx[2]) + (vx[2] - vx[1]) * (py - vy[2]);
                eb  = (vy[2] - vy[0]) * (px - vx[0]) + (vx[0] - vx[2]) * (py - vy[0]);
                eg  = (vy[0] - vy[1]) * (px - vx[1]) + (vx[1] - vx[0]) * (py - vy[1]);
                if (den != 0 && agrees(ea, den) && agrees(eb, den) && agrees(eg, den)) begin
                    accepted = 1'b1;
                end
            end

            if (!accepted) begin
                r.status = tps_pkg::STATUS_OUTSIDE;
                r.piece = '0;
                r.element_id = '0;
                r.last = 1'b1;
                queue_result(r);
                return;
            end

            // The first piece with nonzero area inherits the parent id, the rest draw
            // fresh ids from the wrapping counter.
            kept = 0;
            for (int i = 0; i < 3; i++) begin
                a = from_v[i];
                b = to_v[i];
                area = (vx[b] - vx[a]) * (py - vy[a]) - (px - vx[a]) * (vy[b] - vy[a]);
                if (area != 0) begin
                    r.status = tps_pkg::STATUS_PIECE;
                    r.piece = 2'(i);
                    if (kept == 0) begin
                        r.element_id = it.tri_id;
                    end else begin
                        r.element_id = next_piece_id;
                        next_piece_id = next_piece_id + 1'b1;
                    end
                    r.last = 1'b0;
                    queue_result(r);
                    kept++;
                end
            end

            if (kept == 0) begin
                r.status = tps_pkg::STATUS_EMPTY;
                r.piece = '0;
                r.element_id = '0;
                r.last = 1'b1;
                queue_result(r);
            end else begin
                expected_pieces[expected_pieces.size() - 1].last = 1'b1;
            end
        endfunction

        function void check_piece(piece_result_t got);
            piece_result_t want;

            results_seen++;
            if (int'(got.status) < 3) begin
                status_seen[int'(got.status)]++;
            end
            if (expected_pieces.size() == 0) begin
                report($sformatf("unexpected result: status %0d piece %0d id %0d last %0b",
                                 got.status, got.piece, got.element_id, got.last));
                return;
            end
            want = expected_pieces.pop_front();
            if (got.status !== want.status || got.piece !== want.piece ||
                got.element_id !== want.element_id || got.last !== want.last) begin
                report($sformatf({"expected status %0d piece %0d id %0d last %0b, ",
                                  "got status %0d piece %0d id %0d last %0b"},
                                 want.status, want.piece, want.element_id, want.last,
                                 got.status, got.piece, got.element_id, got.last));
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic [15:0] s_v1_x = '0;
    logic [15:0] s_v1_y = '0;
    logic [15:0] s_v2_x = '0;
    logic [15:0] s_v2_y = '0;
    logic [15:0] s_v3_x = '0;
    logic [15:0] s_v3_y = '0;
    logic [15:0] s_pt_x = '0;
    logic [15:0] s_pt_y = '0;
    logic        s_on_boundary = 1'b0;
    logic [15:0] s_tri_id = '0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_initial_new_id = '0;
    logic        m_ready = 1'b0;

    logic        s_ready;
    logic        cfg_ready;
    logic        m_valid;
    logic [1:0]  m_status;
    logic [1:0]  m_piece;
    logic [15:0] m_element_id;
    logic        m_last;

    split_scoreboard split_check;
    bit          idle_on = 1'b1;
    bit          hold_pending = 1'b0;
    int          cycle_count = 0;

    triangle_point_split dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_v1_x             (s_v1_x),
        .s_v1_y             (s_v1_y),
        .s_v2_x             (s_v2_x),
        .s_v2_y             (s_v2_y),
        .s_v3_x             (s_v3_x),
        .s_v3_y             (s_v3_y),
        .s_pt_x             (s_pt_x),
        .s_pt_y             (s_pt_y),
        .s_on_boundary      (s_on_boundary),
        .s_tri_id           (s_tri_id),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_initial_new_id (cfg_initial_new_id),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_piece            (m_piece),
        .m_element_id       (m_element_id),
        .m_last             (m_last)
    );

    always #5 aclk = ~aclk;

    function automatic tri_item_t mk(int ax, int ay, int bx, int by, int cx, int cy,
                                     int px, int py, bit bnd, int tid);
        tri_item_t it;
        it.v1_x = tps_pkg::coord_t'(ax);
        it.v1_y = tps_pkg::coord_t'(ay);
        it.v2_x = tps_pkg::coord_t'(bx);
        it.v2_y = tps_pkg::coord_t'(by);
        it.v3_x = tps_pkg::coord_t'(cx);
        it.v3_y = tps_pkg::coord_t'(cy);
        it.pt_x = tps_pkg::coord_t'(px);
        it.pt_y = tps_pkg::coord_t'(py);
        it.on_boundary = bnd;
        it.tri_id = tps_pkg::id_t'(tid);
        return it;
    endfunction

    function automatic int rnd(int span);
        return int'($urandom_range(0, 2 * span - 1)) - span;
    endfunction

    function automatic int pick_span();
        case ($urandom_range(0, 3))
            0: begin
                return 8;
            end
            1: begin
                return 200;
            end
            2: begin
                return 4000;
            end
            default: begin
                return 32768;
            end
        endcase
    endfunction

    // Mostly triangles with the point inside or on an edge, plus degenerate shapes
    // and raw noise on every field.
    function automatic tri_item_t random_item();
        int     x[3];
        int     y[3];
        int     ox[3];
        int     oy[3];
        int     px;
        int     py;
        int     span;
        int     kind;
        int     k;
        int     dx;
        int     dy;
        int     rot;
        int     w[3];
        longint wsum;
        bit     bnd;

        kind = $urandom_range(0, 99);
        span = pick_span();
        for (int i = 0; i < 3; i++) begin
            x[i] = rnd(span);
            y[i] = rnd(span);
        end
        px = rnd(span);
        py = rnd(span);
        bnd = $urandom_range(0, 1);

        if (kind < 45) begin
            for (int i = 0; i < 3; i++) begin
                w[i] = $urandom_range(0, 20);
            end
            wsum = w[0] + w[1] + w[2];
            if (wsum == 0) begin
                w[0] = 1;
                wsum = 1;
            end
            px = int'((longint'(w[0]) * x[0] + longint'(w[1]) * x[1]
                       + longint'(w[2]) * x[2]) / wsum);
            py = int'((longint'(w[0]) * y[0] + longint'(w[1]) * y[1]
                       + longint'(w[2]) * y[2]) / wsum);
            bnd = ($urandom_range(0, 3) == 0);
        end else if (kind < 60) begin
            if (span > 4000) begin
                span = 4000;
            end
            x[0] = rnd(20000);
            y[0] = rnd(20000);
            dx = rnd(span);
            dy = rnd(span);
            if (dx == 0) begin
                dx = 1;
            end
            if (dy == 0) begin
                dy = -1;
            end
            x[1] = x[0] + dx;  y[1] = y[0];
            x[2] = x[0];       y[2] = y[0] + dy;
            k = $urandom_range(0, 8);
            case ($urandom_range(0, 2))
                0: begin
                    px = x[0] + k * dx / 8;
                    py = y[0];
                end
                1: begin
                    px = x[0];
                    py = y[0] + k * dy / 8;
                end
                default: begin
                    px = x[0] + dx / 4;
                    py = y[0] + dy / 4;
                end
            endcase
            bnd = ($urandom_range(0, 4) != 0);
        end else if (kind < 70) begin
            k = $urandom_range(0, 2);
            if ($urandom_range(0, 1) == 1) begin
                px = x[k];
                py = y[k];
            end else begin
                px = (x[k] + x[(k + 1) % 3]) / 2;
                py = (y[k] + y[(k + 1) % 3]) / 2;
            end
        end else if (kind < 80) begin
            // All three vertices on one line, often an axis-parallel one.
            x[0] = rnd(1000);
            y[0] = rnd(1000);
            dx = rnd(8);
            dy = rnd(8);
            case ($urandom_range(0, 2))
                0: begin
                    dx = 0;
                end
                1: begin
                    dy = 0;
                end
                default: begin
                end
            endcase
            ox[0] = x[0];
            oy[0] = y[0];
            for (int i = 0; i < 3; i++) begin
                k = int'($urandom_range(0, 6)) - 3;
                x[i] = ox[0] + k * dx;
                y[i] = oy[0] + k * dy;
            end
            k = int'($urandom_range(0, 8)) - 4;
            px = ox[0] + k * dx;
            py = oy[0] + k * dy;
            bnd = ($urandom_range(0, 3) != 0);
        end else if (kind < 90) begin
            return mk(rnd(32768), rnd(32768), rnd(32768), rnd(32768), rnd(32768),
                      rnd(32768), rnd(32768), rnd(32768), bnd,
                      int'($urandom_range(0, 65535)));
        end

        rot = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) begin
            ox[i] = x[(i + rot) % 3];
            oy[i] = y[(i + rot) % 3];
        end
        if ($urandom_range(0, 1) == 1) begin
            k = ox[1];  ox[1] = ox[2];  ox[2] = k;
            k = oy[1];  oy[1] = oy[2];  oy[2] = k;
        end
        return mk(ox[0], oy[0], ox[1], oy[1], ox[2], oy[2], px, py, bnd,
                  int'($urandom_range(0, 65535)));
    endfunction

    // A gap of zero keeps valid high straight into the next transfer.
    task automatic send_triangle(tri_item_t it, bit no_gap);
        int gap;
        gap = (idle_on && !no_gap) ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_v1_x        <= it.v1_x;
        s_v1_y        <= it.v1_y;
        s_v2_x        <= it.v2_x;
        s_v2_y        <= it.v2_y;
        s_v3_x        <= it.v3_x;
        s_v3_y        <= it.v3_y;
        s_pt_x        <= it.pt_x;
        s_pt_y        <= it.pt_y;
        s_on_boundary <= it.on_boundary;
        s_tri_id      <= it.tri_id;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        split_check.note_triangle(it);
    endtask

    task automatic send_random(int count, bit no_gap);
        repeat (count) send_triangle(random_item(), no_gap);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (split_check.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_first_id(tps_pkg::id_t value);
        cfg_valid          <= 1'b1;
        cfg_initial_new_id <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        split_check.load_first_id(value);
        cfg_valid <= 1'b0;
    endtask

    initial begin : result_sink
        int stall;
        forever begin
            stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (hold_pending) begin
                stall = LONG_HOLD;
                hold_pending = 1'b0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        piece_result_t got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", CYCLE_LIMIT);
            $display("** triangle_point_split: FAILED **");
            $finish;
        end else if (aresetn && m_valid && m_ready) begin
            got.status     = tps_pkg::status_t'(m_status);
            got.piece      = m_piece;
            got.element_id = m_element_id;
            got.last       = m_last;
            split_check.check_piece(got);
        end
    end

    initial begin : stimulus
        split_check = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        write_first_id(16'h0005);
        send_triangle(mk(0, 0, 100, 0, 0, 100, 10, 10, 0, 16'h0001), 0);
        send_triangle(mk(0, 0, 0, 100, 100, 0, 20, 30, 0, 16'h0002), 0);
        send_triangle(mk(0, 0, 100, 0, 0, 100, 80, 80, 0, 16'h0003), 0);
        send_triangle(mk(0, 0, 100, 0, 0, 100, 0, 0, 0, 16'h0004), 0);
        send_triangle(mk(0, 0, 100, 0, 0, 100, 50, 50, 0, 16'h0005), 0);
        send_triangle(mk(0, 0, 100, 0, 0, 100, 50, 0, 1, 16'h0006), 0);
        send_triangle(mk(0, 0, 100, 0, 0, 100, 0, 70, 1, 16'h0007), 0);
        send_triangle(mk(-5, -5, 5, -5, 5, 5, 5, 0, 1, 16'h0008), 0);
        send_triangle(mk(0, 0, 100, 0, 0, 100, 150, 0, 1, 16'h0009), 0);
        send_triangle(mk(0, 0, 100, 0, 0, 100, 30, 30, 1, 16'h000A), 0);
        // Collinear vertices: only the boundary rule can let the point in, and
        // then every piece has zero area.
        send_triangle(mk(0, 0, 10, 10, 20, 20, 5, 5, 0, 16'h000B), 0);
        send_triangle(mk(0, 7, 10, 7, 20, 7, 5, 7, 1, 16'h000C), 0);
        send_triangle(mk(3, 3, 3, 3, 3, 3, 3, 3, 1, 16'h000D), 0);
        send_triangle(mk(0, 7, 10, 7, 20, 7, 5, 7, 0, 16'h000E), 0);
        send_triangle(mk(-32768, -32768, 32767, -32768, -32768, 32767, -1, -1, 0,
                         16'hFFFF), 0);
        send_triangle(mk(-32768, -32768, 32767, -32768, -32768, 32767, -32768, -32768, 1,
                         16'h0000), 0);
        send_triangle(mk(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767, 0,
                         16'h8000), 0);
        send_triangle(mk(32767, 32767, -32768, 32767, 32767, -32768, 0, 0, 1, 16'h7FFF), 0);
        send_triangle(mk(-32768, 0, 32767, 0, 0, -32768, 0, 0, 1, 16'h0000), 0);
        send_triangle(mk(100, -200, -300, 400, 250, 350, 20, 180, 0, 16'h1234), 0);
        drain_results();

        // The id counter must wrap from all ones to zero.
        write_first_id(16'hFFFF);
        send_triangle(mk(0, 0, 100, 0, 0, 100, 10, 10, 0, 16'hFFFF), 0);
        send_triangle(mk(0, 0, 100, 0, 0, 100, 10, 10, 0, 16'h0000), 0);
        send_triangle(mk(0, 0, 100, 0, 0, 100, 10, 10, 0, 16'hAAAA), 0);
        drain_results();

        write_first_id(16'h0000);
        send_random(50, 0);
        // Long result stall while inputs keep coming back to back.
        hold_pending = 1'b1;
        send_random(25, 1);
        drain_results();
        idle_on = 1'b0;
        send_random(40, 0);
        idle_on = 1'b1;
        drain_results();

        write_first_id(tps_pkg::id_t'($urandom_range(0, 65535)));
        send_random(40, 0);
        drain_results();

        write_first_id(16'hFFFE);
        send_random(35, 0);
        drain_results();
        repeat (12) @(posedge aclk);

        if (split_check.pending() != 0) begin
            split_check.report($sformatf("%0d results never arrived",
                                         split_check.pending()));
        end
        $display("Run covered %0d triangles and %0d results: %0d pieces, %0d outside, %0d empty.",
                 split_check.triangles_seen, split_check.results_seen,
                 split_check.status_seen[0], split_check.status_seen[1],
                 split_check.status_seen[2]);
        $display("First-id values included 0, 5, 0xFFFE and 0xFFFF; %0d mismatches in total.",
                 split_check.errors);
        if (split_check.errors == 0) begin
            $display("** triangle_point_split: PASSED **");
        end else begin
            $display("** triangle_point_split: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/tps_pkg.sv
hdl/triangle_point_split.sv
hdl/tps_checker.sv
tb/testbench.sv
